[src/mtt_pkg.sv]
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and constants for the minimum tournament tree.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int KEY_W      = 32;
  localparam int SEED_W     = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [KEY_W-1:0]  KEY_EMPTY = {KEY_W{1'b1}};
  localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [SEED_W-1:0] SEED_ONE  = 16'h0001;

  // register word index
  localparam logic [APB_ADDR_W-3:0] REG_TIE_SEED = 1'b0;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LEAF  = 5'b00100,
    ST_LEVEL = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

[src/min_tournament_tree_update.sv]
// ----------------------------------------------------------------------------
// min_tournament_tree_update
// Tournament tree keeping the minimum key and its leaf slot at the root.
// ----------------------------------------------------------------------------
// Each input transfer writes its leaf, then walks the path to the root one tree
//   level per cycle through the single merge unit; ST_DONE registers the result.
// A new item is taken only in ST_IDLE, after the previous result has been issued.
// Out-of-range slot: the tree is left unchanged and the current root is reported.
// Reset: a clearing sweep over every node from 1 to 2*TREE_N-1 runs
//   first, in_ready_o stays low meanwhile; register writes are still taken.
module min_tournament_tree_update #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [$clog2(LEAF_COUNT)-1:0]        leaf_slot_i,
  input  logic [mtt_pkg::KEY_W-1:0]            new_key_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [mtt_pkg::KEY_W-1:0]            min_key_o,
  output logic [$clog2(LEAF_COUNT)-1:0]        min_slot_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mtt_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [mtt_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [mtt_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  import mtt_pkg::*;

  localparam int SLOT_W = $clog2(LEAF_COUNT);
  localparam int ADDR_W = SLOT_W + 1;
  localparam int DATA_W = KEY_W + SLOT_W;
  localparam logic [SLOT_W:0]   LEAF_LIM  = (SLOT_W + 1)'(LEAF_COUNT);
  localparam logic [SLOT_W:0]   TREE_N    = {1'b1, {SLOT_W{1'b0}}};
  localparam logic [ADDR_W-1:0] LAST_NODE = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0] ROOT_NODE = ADDR_W'(1);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] node_q, node_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [KEY_W-1:0]  carry_key_q, carry_key_d;
  logic [SLOT_W-1:0] carry_slot_q, carry_slot_d;
  logic [SLOT_W-1:0] half_q, half_d;
  logic [SLOT_W-1:0] mask_q, mask_d;
  logic [SLOT_W-1:0] clr_slot_q, clr_slot_d;
  logic [SLOT_W:0]   clr_step_q, clr_step_d;
  logic [KEY_W-1:0]  root_key_q, root_key_d;
  logic [SLOT_W-1:0] root_slot_q, root_slot_d;
  logic              out_valid_q, out_valid_d;
  logic [KEY_W-1:0]  min_key_q, min_key_d;
  logic [SLOT_W-1:0] min_slot_q, min_slot_d;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic [KEY_W-1:0]  sib_key;
  logic [SLOT_W-1:0] sib_slot;
  logic [KEY_W-1:0]  left_key, right_key, win_key;
  logic [SLOT_W-1:0] left_slot, right_slot, win_slot;
  logic [SLOT_W-1:0] rfirst;
  logic              right_real;
  logic              tie_bit, tie_used, lfsr_adv;
  logic [ADDR_W-1:0] parent;
  logic [ADDR_W-1:0] node_inc;
  logic              in_xfer, in_range, slot_free;

  logic              seed_we;
  logic [SEED_W-1:0] seed_val;

  // configuration port
  assign pready  = 1'b1;
  assign seed_we = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_TIE_SEED);
  assign prdata  = (paddr[APB_ADDR_W-1:2] == REG_TIE_SEED)
                   ? APB_DATA_W'(seed_val) : '0;

  mtt_tie_lfsr u_tie_lfsr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_we_i (seed_we),
    .seed_i    (pwdata[SEED_W-1:0]),
    .advance_i (lfsr_adv),
    .bit_o     (tie_bit),
    .seed_o    (seed_val)
  );

  mtt_node_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // path child sits left when its node index is even
  assign sib_key    = mem_rdata[DATA_W-1:SLOT_W];
  assign sib_slot   = mem_rdata[SLOT_W-1:0];
  assign left_key   = node_q[0] ? sib_key      : carry_key_q;
  assign left_slot  = node_q[0] ? sib_slot     : carry_slot_q;
  assign right_key  = node_q[0] ? carry_key_q  : sib_key;
  assign right_slot = node_q[0] ? carry_slot_q : sib_slot;
  assign rfirst     = (slot_q & ~mask_q) | half_q;
  assign right_real = {1'b0, rfirst} < LEAF_LIM;
  assign parent     = node_q >> 1;
  assign node_inc   = node_q + ADDR_W'(1);

  mtt_merge_unit #(
    .SLOT_W (SLOT_W)
  ) u_merge_unit (
    .left_key_i   (left_key),
    .left_slot_i  (left_slot),
    .right_key_i  (right_key),
    .right_slot_i (right_slot),
    .right_real_i (right_real),
    .tie_bit_i    (tie_bit),
    .win_key_o    (win_key),
    .win_slot_o   (win_slot),
    .tie_used_o   (tie_used)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_range   = {1'b0, leaf_slot_i} < LEAF_LIM;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    node_d       = node_q;
    slot_d       = slot_q;
    key_d        = key_q;
    carry_key_d  = carry_key_q;
    carry_slot_d = carry_slot_q;
    half_d       = half_q;
    mask_d       = mask_q;
    clr_slot_d   = clr_slot_q;
    clr_step_d   = clr_step_q;
    root_key_d   = root_key_q;
    root_slot_d  = root_slot_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    min_key_d    = min_key_q;
    min_slot_d   = min_slot_q;
    mem_we       = 1'b0;
    mem_waddr    = node_q;
    mem_wdata    = {carry_key_q, carry_slot_q};
    mem_raddr    = node_q ^ ADDR_W'(1);
    lfsr_adv     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // inner nodes get the slot of their leftmost leaf
        mem_we    = 1'b1;
        mem_wdata = {KEY_EMPTY, clr_slot_q};
        if (node_q == LAST_NODE) begin
          state_d = ST_IDLE;
        end else begin
          node_d = node_inc;
          if ((node_q & node_inc) == '0) begin
            clr_slot_d = '0;
            clr_step_d = clr_step_q >> 1;
          end else begin
            clr_slot_d = clr_slot_q + clr_step_q[SLOT_W-1:0];
          end
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          slot_d = leaf_slot_i;
          key_d  = new_key_i;
          node_d = {1'b1, leaf_slot_i};
          state_d = in_range ? ST_LEAF : ST_DONE;
        end
      end
      ST_LEAF: begin
        mem_we       = 1'b1;
        mem_wdata    = {key_q, slot_q};
        carry_key_d  = key_q;
        carry_slot_d = slot_q;
        half_d       = SLOT_W'(1);
        mask_d       = SLOT_W'(1);
        state_d      = ST_LEVEL;
      end
      ST_LEVEL: begin
        mem_we       = 1'b1;
        mem_waddr    = parent;
        mem_wdata    = {win_key, win_slot};
        mem_raddr    = parent ^ ADDR_W'(1);
        lfsr_adv     = tie_used;
        carry_key_d  = win_key;
        carry_slot_d = win_slot;
        node_d       = parent;
        half_d       = half_q << 1;
        mask_d       = (mask_q << 1) | SLOT_W'(1);
        if (parent == ROOT_NODE) begin
          root_key_d  = win_key;
          root_slot_d = win_slot;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          min_key_d   = root_key_q;
          min_slot_d  = root_slot_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      node_q      <= ROOT_NODE;
      clr_slot_q  <= '0;
      clr_step_q  <= TREE_N;
      root_key_q  <= KEY_EMPTY;
      root_slot_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      clr_slot_q  <= clr_slot_d;
      clr_step_q  <= clr_step_d;
      root_key_q  <= root_key_d;
      root_slot_q <= root_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    key_q        <= key_d;
    carry_key_q  <= carry_key_d;
    carry_slot_q <= carry_slot_d;
    half_q       <= half_d;
    mask_q       <= mask_d;
    min_key_q    <= min_key_d;
    min_slot_q   <= min_slot_d;
  end

  assign out_valid_o = out_valid_q;
  assign min_key_o   = min_key_q;
  assign min_slot_o  = min_slot_q;

endmodule

[src/mtt_node_ram.sv]
// ----------------------------------------------------------------------------
// mtt_node_ram
// Node store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtt_node_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 42
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/mtt_tie_lfsr.sv]
// ----------------------------------------------------------------------------
// mtt_tie_lfsr
// Seed register and 16-bit Galois LFSR for random tie breaking.
// ----------------------------------------------------------------------------
module mtt_tie_lfsr (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       seed_we_i,
  input  logic [mtt_pkg::SEED_W-1:0] seed_i,
  input  logic                       advance_i,
  output logic                       bit_o,
  output logic [mtt_pkg::SEED_W-1:0] seed_o
);

  import mtt_pkg::*;

  logic [SEED_W-1:0] seed_q, seed_d;
  logic [SEED_W-1:0] lfsr_q, lfsr_d;
  logic [SEED_W-1:0] seed_fix;

  // an all-zero state would lock up
  assign seed_fix = (seed_i == '0) ? SEED_ONE : seed_i;

  always_comb begin
    seed_d = seed_q;
    lfsr_d = lfsr_q;
    priority if (seed_we_i) begin
      seed_d = seed_fix;
      lfsr_d = seed_fix;
    end else if (advance_i) begin
      lfsr_d = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
    end else begin
      lfsr_d = lfsr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_ONE;
      lfsr_q <= SEED_ONE;
    end else begin
      seed_q <= seed_d;
      lfsr_q <= lfsr_d;
    end
  end

  assign bit_o  = lfsr_q[0];
  assign seed_o = seed_q;

endmodule

[src/mtt_merge_unit.sv]
// ----------------------------------------------------------------------------
// mtt_merge_unit
// Compare-select of two child nodes; right wins when strictly smaller,
// ties go to the LFSR bit unless the right child covers only padding.
// ----------------------------------------------------------------------------
module mtt_merge_unit #(
  parameter int SLOT_W = 10
) (
  input  logic [mtt_pkg::KEY_W-1:0] left_key_i,
  input  logic [SLOT_W-1:0]         left_slot_i,
  input  logic [mtt_pkg::KEY_W-1:0] right_key_i,
  input  logic [SLOT_W-1:0]         right_slot_i,
  input  logic                      right_real_i,
  input  logic                      tie_bit_i,
  output logic [mtt_pkg::KEY_W-1:0] win_key_o,
  output logic [SLOT_W-1:0]         win_slot_o,
  output logic                      tie_used_o
);

  import mtt_pkg::*;

  logic right_less;
  logic take_right;

  assign right_less = right_key_i < left_key_i;
  assign tie_used_o = (right_key_i == left_key_i) && right_real_i;
  assign take_right = right_less || (tie_used_o && tie_bit_i);
  assign win_key_o  = take_right ? right_key_i  : left_key_i;
  assign win_slot_o = take_right ? right_slot_i : left_slot_i;

endmodule

[src/mtt_checker.sv]
// ----------------------------------------------------------------------------
// mtt_checker
// Port-level checks for the minimum tournament tree, bound to the top level.
// ----------------------------------------------------------------------------
module mtt_checker #(
  parameter int LEAF_COUNT = 1024
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [mtt_pkg::KEY_W-1:0]       min_key_o,
  input logic [$clog2(LEAF_COUNT)-1:0]   min_slot_o
);

  import mtt_pkg::*;

  localparam int SLOT_W = $clog2(LEAF_COUNT);
  localparam logic [SLOT_W:0] LEAF_LIM = (SLOT_W + 1)'(LEAF_COUNT);

  // one item in flight: no transfer in the cycle after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on back-to-back cycles");

  // a transfer in never yields a result in the very next cycle on an idle output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  // padding slots are never reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, min_slot_o} < LEAF_LIM))
    else $error("reported slot beyond leaf count");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(min_key_o) && $stable(min_slot_o))
    else $error("stalled result changed");

endmodule

bind min_tournament_tree_update mtt_checker #(
  .LEAF_COUNT (LEAF_COUNT)
) u_mtt_checker (.*);
